>>> rtl/core/sorted_set_batch_engine_macros.svh
// Assertion macros shared by the sorted set batch engine.
// No dependencies; included inside module bodies.
`ifndef SORTED_SET_BATCH_ENGINE_MACROS_SVH
`define SORTED_SET_BATCH_ENGINE_MACROS_SVH

// same-cycle implication
`define SSBE_CHECK(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SSBE_CHECK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ssbe_pkg.sv
// Shared types and constants of the sorted set batch engine.
// No dependencies.
package ssbe_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int CMD_W    = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_KEEP   = 2'd2;

    typedef struct packed {
        logic signed [VAL_W-1:0] val;
        logic                    valid;
        logic                    mark;
    } cell_state_t;

    typedef struct packed {
        logic ins;   // insert broadcast value at its place
        logic rem;   // remove matching entry
        logic mark;  // set keep mark on matching entry
        logic rot;   // shift down by one, head goes to tail
        logic app;   // head is re-appended during rot
        logic clr;   // clear all keep marks
    } cell_op_t;

endpackage

>>> rtl/core/ssbe_cell.sv
// One slot of the sorted chain: value, valid and keep mark.
// Depends on ssbe_pkg.
module ssbe_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ssbe_pkg::cell_op_t          op,
    input  logic signed [31:0]          bcast,
    input  ssbe_pkg::cell_state_t       prev_q,
    input  logic                        prev_lt,
    input  ssbe_pkg::cell_state_t       next_q,
    input  ssbe_pkg::cell_state_t       head_q,
    output ssbe_pkg::cell_state_t       q,
    output logic                        lt,
    output logic                        eq
);
    import ssbe_pkg::*;

    cell_state_t q_reg;
    cell_state_t q_next;

    assign q  = q_reg;
    assign lt = q_reg.valid && (q_reg.val < bcast);
    assign eq = q_reg.valid && (q_reg.val == bcast);

    always_comb begin
        q_next = q_reg;
        if (op.ins && !lt) begin
            if (prev_lt) begin
                q_next.val   = bcast;
                q_next.valid = 1'b1;
                q_next.mark  = 1'b0;
            end else begin
                q_next = prev_q;
            end
        end
        if (op.rem && !lt) begin
            q_next = next_q;
        end
        if (op.mark && eq) begin
            q_next.mark = 1'b1;
        end
        if (op.rot) begin
            q_next = next_q;
            if (q_reg.valid && !next_q.valid) begin
                q_next.val   = head_q.val;
                q_next.valid = op.app;
                q_next.mark  = 1'b0;
            end
        end
        if (op.clr) begin
            q_next.mark = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg.val <= q_next.val;
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
            q_reg.mark  <= 1'b0;
        end else begin
            q_reg.valid <= q_next.valid;
            q_reg.mark  <= q_next.mark;
        end
    end

endmodule

>>> rtl/core/ssbe_chain.sv
// Row of CAPACITY cells kept in ascending order, with match and full flags.
// Depends on ssbe_pkg and ssbe_cell.
module ssbe_chain (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ssbe_pkg::cell_op_t      op,
    input  logic signed [31:0]      bcast,
    output ssbe_pkg::cell_state_t   head_q,
    output logic                    present,
    output logic                    full
);
    import ssbe_pkg::*;

    cell_state_t q_arr [CAPACITY];
    logic        lt_arr [CAPACITY];
    logic [CAPACITY-1:0] eq_vec;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            cell_state_t prev_s;
            cell_state_t next_s;
            logic        prev_l;
            logic        eq_s;

            if (i == 0) begin : g_first
                assign prev_s = '0;
                assign prev_l = 1'b1;
            end else begin : g_mid
                assign prev_s = q_arr[i-1];
                assign prev_l = lt_arr[i-1];
            end

            if (i == CAPACITY - 1) begin : g_last
                assign next_s = '0;
            end else begin : g_inner
                assign next_s = q_arr[i+1];
            end

            ssbe_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .op      (op),
                .bcast   (bcast),
                .prev_q  (prev_s),
                .prev_lt (prev_l),
                .next_q  (next_s),
                .head_q  (q_arr[0]),
                .q       (q_arr[i]),
                .lt      (lt_arr[i]),
                .eq      (eq_s)
            );

            assign eq_vec[i] = eq_s;
        end
    endgenerate

    assign head_q  = q_arr[0];
    assign present = |eq_vec;
    assign full    = q_arr[CAPACITY-1].valid;

endmodule

>>> rtl/core/sorted_set_batch_engine.sv
// Channel | dir | tdata        | tuser                          | tlast
// s_      | in  | value[31:0]  | command[1:0], has_value[2]     | batch_end
// m_      | out | element[31:0]| set_empty[0], dropped[1]       | final_item
// One element per cycle outside batch ends; each cell compares against the broadcast value.
// Batch end: keep filters out unmarked members, then the dump takes max(N,1) words, N = members.
// The dump rotates the chain one cell per word; m_tready low stalls the rotation.
// No clearing pass after reset; s_tready is low from batch end until the last word is issued.
// Top level: control, counters and output register. Depends on ssbe_pkg, ssbe_chain.
module sorted_set_batch_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [2:0]  s_tuser,   // command[1:0], has_value[2]
    input  logic        s_tlast,   // batch_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // element[31:0]
    output logic [1:0]  m_tuser,   // set_empty[0], dropped[1]
    output logic        m_tlast    // final_item
);
    import ssbe_pkg::*;
    `include "sorted_set_batch_engine_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_FILTER = 3'b010,
        ST_DUMP   = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;
    logic              ovf_reg, ovf_next;
    logic              m_valid_reg;
    logic [31:0]       m_data_reg;
    logic [1:0]        m_user_reg;
    logic              m_last_reg;

    cell_op_t          op;
    cell_state_t       head_q;
    logic              present;
    logic              full;
    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [CMD_W-1:0]  cmd;
    logic              has_value;

    assign cmd       = s_tuser[1:0];
    assign has_value = s_tuser[2];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    ssbe_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .bcast   ($signed(s_tdata)),
        .head_q  (head_q),
        .present (present),
        .full    (full)
    );

    always_comb begin
        op         = '0;
        state_next = state_reg;
        count_next = count_reg;
        steps_next = steps_reg;
        ovf_next   = ovf_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (has_value) begin
                        case (cmd)
                            CMD_ADD: begin
                                if (!present && !full) begin
                                    op.ins     = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end else if (!present) begin
                                    ovf_next = 1'b1;
                                end
                            end
                            CMD_REMOVE: begin
                                if (present) begin
                                    op.rem     = 1'b1;
                                    count_next = count_reg - 1'b1;
                                end
                            end
                            CMD_KEEP: op.mark = 1'b1;
                            default: ;
                        endcase
                    end
                    if (s_tlast) begin
                        state_next = (cmd == CMD_KEEP) ? ST_FILTER : ST_DUMP;
                        steps_next = count_next;
                    end
                end
            end
            ST_FILTER: begin
                if (steps_reg == '0) begin
                    state_next = ST_DUMP;
                    steps_next = count_reg;
                end else begin
                    op.rot     = 1'b1;
                    op.app     = head_q.mark;
                    steps_next = steps_reg - 1'b1;
                    if (!head_q.mark) begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    op.clr   = 1'b1;
                    if (steps_reg != '0) begin
                        op.rot     = 1'b1;
                        op.app     = 1'b1;
                        steps_next = steps_reg - 1'b1;
                    end
                    if (steps_reg <= CNT_W'(1)) begin
                        state_next = ST_IDLE;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            steps_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            steps_reg <= steps_next;
            ovf_reg   <= ovf_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= (steps_reg == '0) ? 32'd0 : head_q.val;
            m_last_reg <= (steps_reg <= CNT_W'(1));
            m_user_reg <= {ovf_reg, (steps_reg == '0)};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `SSBE_CHECK(a_count_max, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY), "member count over capacity")
    `SSBE_CHECK(a_full_count, aclk, aresetn, full, count_reg == CNT_W'(CAPACITY), "last cell valid but count short")
    `SSBE_CHECK(a_empty_final, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast, "empty marker not final")
    `SSBE_CHECK_NEXT(a_end_busy, aclk, aresetn, accept && s_tlast, !s_tready, "batch end did not start dump")

endmodule
